/* rtl/cmaf_pkg.sv */
// Shared types, constants and helpers for the centered moving average filter.
// No dependencies; cmaf_front, cmaf_back and the top level import this package.
package cmaf_pkg;

   localparam int WIN_W  = 4;   // window length register
   localparam int HALF_W = 3;   // half width, at most (15-1)/2 = 7
   localparam int DIV_W  = 4;   // divisor 2h+1, at most 15

   localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd5;

   typedef struct packed {
      logic [HALF_W-1:0] half;
      logic              last_out;
   } job_type;

   // Half width from the window length: length 0 acts as 1, even lengths truncate.
   function automatic logic [HALF_W-1:0] half_width(input logic [WIN_W-1:0] win,
                                                    input int unsigned max_half);
      logic [WIN_W-1:0] t;
      t = (win == '0) ? '0 : ((win - WIN_W'(1)) >> 1);
      if (int'(t) > int'(max_half)) begin
         return HALF_W'(max_half);
      end
      return t[HALF_W-1:0];
   endfunction

endpackage

/* rtl/cmaf_queue.sv */
// Small job queue between the front and back parts of the filter.
// Depends on nothing; the top level picks the entry width.
module cmaf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

/* rtl/cmaf_front.sv */
// Front part: accepts samples, keeps the sample history and stream counters,
// and releases one averaging job per cycle into the queue while it is not full. Uses cmaf_pkg.
module cmaf_front #(
   parameter int MAX_HALF_WINDOW = 7,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0]                 req_sample,
   input  logic                                          req_is_last,
   input  logic [cmaf_pkg::WIN_W-1:0]                    window_size,
   input  logic                                          hist_busy,
   input  logic                                          q_full,
   input  logic                                          q_empty,
   output logic                                          push,
   output logic [$clog2(MAX_HALF_WINDOW+2)-1:0]          push_off,
   output cmaf_pkg::job_type                             push_job,
   input  logic [$clog2(2*MAX_HALF_WINDOW+1)-1:0]        hist_idx,
   output logic signed [SAMPLE_BITS-1:0]                 hist_data
);
   import cmaf_pkg::*;

   localparam int HIST_DEPTH  = 2 * MAX_HALF_WINDOW + 1;
   localparam int COUNT_CAP   = 2 * MAX_HALF_WINDOW + 1;
   localparam int PENDING_CAP = MAX_HALF_WINDOW + 1;
   localparam int CNT_W       = $clog2(COUNT_CAP + 1);
   localparam int PEND_W      = $clog2(PENDING_CAP + 1);
   localparam int MW          = (CNT_W > HALF_W) ? CNT_W : HALF_W;

   logic signed [SAMPLE_BITS-1:0] hist_ff [HIST_DEPTH];
   logic [CNT_W-1:0]  rc_ff, rc_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              gen_ff, gen_in;
   logic              last_ff, last_in;

   logic              accept;
   logic [HALF_W-1:0] hw, h0, h;
   logic [PEND_W-1:0] off;
   logic [CNT_W-1:0]  jlow;
   logic              emit, stop, stop_now;

   assign req_ready = !gen_ff && q_empty && !hist_busy;
   assign accept    = req_valid && req_ready;
   assign hist_data = (int'(hist_idx) < HIST_DEPTH) ? hist_ff[hist_idx] : '0;

   // Decide the next output of the current sample: emit it, or stop.
   always_comb begin
      hw   = half_width(window_size, MAX_HALF_WINDOW);
      off  = pend_ff - PEND_W'(1);
      jlow = (rc_ff >= CNT_W'(pend_ff)) ? rc_ff - CNT_W'(pend_ff) : '0;
      h0   = (MW'(hw) < MW'(jlow)) ? hw : HALF_W'(jlow);
      h    = h0;
      emit = 1'b0;
      stop = 1'b0;
      if (pend_ff == '0) begin
         stop = 1'b1;
      end else if (last_ff) begin
         if (MW'(off) < MW'(h0)) begin
            h = HALF_W'(off);
         end
         emit = 1'b1;
      end else if (MW'(off) < MW'(h0)) begin
         stop = 1'b1;
      end else begin
         emit = 1'b1;
      end
   end

   assign push              = gen_ff && emit && !q_full;
   assign stop_now          = gen_ff && stop;
   assign push_off          = off;
   assign push_job.half     = h;
   assign push_job.last_out = last_ff && (pend_ff == PEND_W'(1));

   always_comb begin
      rc_in   = rc_ff;
      pend_in = pend_ff;
      gen_in  = gen_ff;
      last_in = last_ff;
      if (accept) begin
         rc_in   = (int'(rc_ff) < COUNT_CAP) ? rc_ff + CNT_W'(1) : rc_ff;
         pend_in = (int'(pend_ff) < PENDING_CAP) ? pend_ff + PEND_W'(1) : pend_ff;
         gen_in  = 1'b1;
         last_in = req_is_last;
      end else if (push) begin
         pend_in = pend_ff - PEND_W'(1);
      end else if (stop_now) begin
         gen_in = 1'b0;
         if (last_ff) begin
            rc_in   = '0;
            pend_in = '0;
         end
      end
   end

   // Shift the history, newest at entry 0.
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_ff[0] <= req_sample;
         for (int i = 1; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff   <= '0;
         pend_ff <= '0;
         gen_ff  <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         rc_ff   <= rc_in;
         pend_ff <= pend_in;
         gen_ff  <= gen_in;
         last_ff <= last_in;
      end
   end
endmodule

/* rtl/cmaf_back.sv */
// Back part: pops jobs, sums the window serially from the front's history,
// divides by 2h+1 one bit a cycle and drives the result register. Uses cmaf_pkg.
module cmaf_back #(
   parameter int MAX_HALF_WINDOW = 7,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                                                         clock,
   input  logic                                                         reset,
   input  logic                                                         q_empty,
   input  logic [$clog2(MAX_HALF_WINDOW+2)+$bits(cmaf_pkg::job_type)-1:0] q_data,
   output logic                                                         pop,
   output logic                                                         hist_busy,
   output logic [$clog2(2*MAX_HALF_WINDOW+1)-1:0]                       hist_idx,
   input  logic signed [SAMPLE_BITS-1:0]                                hist_data,
   output logic                                                         rsp_valid,
   input  logic                                                         rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]                                rsp_average,
   output logic                                                         rsp_last_out
);
   import cmaf_pkg::*;

   localparam int PEND_W = $clog2(MAX_HALF_WINDOW + 2);
   localparam int IDX_W  = $clog2(2 * MAX_HALF_WINDOW + 1);
   localparam int JOB_W  = $bits(job_type);
   localparam int SUM_W  = SAMPLE_BITS + DIV_W;
   localparam int DC_W   = $clog2(SUM_W);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ACC   = 3'd1;
   localparam logic [2:0] ST_PREP  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [DIV_W-1:0]         left_ff, left_in;
   logic [DIV_W-1:0]         div_ff, div_in;
   logic                     last_ff, last_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [DIV_W-1:0]         rem_ff, rem_in;
   logic [DC_W-1:0]          dcnt_ff, dcnt_in;
   logic                     rvalid_ff, rvalid_in;
   logic signed [SAMPLE_BITS-1:0] ravg_ff, ravg_in;
   logic                     rlast_ff, rlast_in;

   logic [PEND_W-1:0]        job_off;
   job_type                  job;
   logic [DIV_W:0]           trial;
   logic [SUM_W-1:0]         quot;

   assign job_off      = q_data[PEND_W+JOB_W-1:JOB_W];
   assign job          = q_data[JOB_W-1:0];
   assign pop          = (state_ff == ST_IDLE) && !q_empty;
   assign hist_busy    = (state_ff == ST_ACC);
   assign hist_idx     = idx_ff;
   assign rsp_valid    = rvalid_ff;
   assign rsp_average  = ravg_ff;
   assign rsp_last_out = rlast_ff;
   assign trial        = {rem_ff, mag_ff[SUM_W-1]};

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      left_in   = left_ff;
      div_in    = div_ff;
      last_in   = last_ff;
      sum_in    = sum_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      rem_in    = rem_ff;
      dcnt_in   = dcnt_ff;
      rvalid_in = rvalid_ff && !rsp_ready;
      ravg_in   = ravg_ff;
      rlast_in  = rlast_ff;
      quot      = neg_ff ? -mag_ff : mag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               idx_in   = IDX_W'(job_off) - IDX_W'(job.half);
               left_in  = {job.half, 1'b0};
               div_in   = {job.half, 1'b1};
               last_in  = job.last_out;
               sum_in   = '0;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            // accumulate one history entry per cycle, lowest index first
            sum_in = sum_ff + SUM_W'(hist_data);
            idx_in = idx_ff + IDX_W'(1);
            if (left_ff == '0) begin
               state_in = ST_PREP;
            end else begin
               left_in = left_ff - DIV_W'(1);
            end
         end
         ST_PREP: begin
            neg_in   = sum_ff[SUM_W-1];
            mag_in   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
            rem_in   = '0;
            dcnt_in  = DC_W'(SUM_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring division, quotient bits shift into the magnitude
            if (trial >= {1'b0, div_ff}) begin
               rem_in = DIV_W'(trial - {1'b0, div_ff});
               mag_in = {mag_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DIV_W-1:0];
               mag_in = {mag_ff[SUM_W-2:0], 1'b0};
            end
            if (dcnt_ff == '0) begin
               state_in = ST_WRITE;
            end else begin
               dcnt_in = dcnt_ff - DC_W'(1);
            end
         end
         ST_WRITE: begin
            if (!rvalid_ff || rsp_ready) begin
               rvalid_in = 1'b1;
               ravg_in   = quot[SAMPLE_BITS-1:0];
               rlast_in  = last_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      left_ff <= left_in;
      div_ff  <= div_in;
      last_ff <= last_in;
      sum_ff  <= sum_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      dcnt_ff <= dcnt_in;
      ravg_ff <= ravg_in;
      rlast_ff <= rlast_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end
endmodule

/* rtl/centered_moving_average_filter.sv */
// Top level of the centered moving average filter with shrinking edges.
// Depends on cmaf_pkg, cmaf_front, cmaf_queue and cmaf_back.
//
//   channel | ports                               | direction | moves
//   --------+-------------------------------------+-----------+---------------------------
//   req     | req_valid req_ready req_sample      | in        | one sample word
//           | req_is_last                         |           |
//   rsp     | rsp_valid rsp_ready rsp_average     | out       | one average word
//           | rsp_last_out                        |           |
//   csr     | csr_valid csr_ready csr_data        | in        | window length word
//
// Each output pops its job, sums the 2h+1 window entries, takes the magnitude,
// runs the bit-serial divider over the SAMPLE_BITS+4 bit sum and loads the
// result register. Accept a sample only once the front has released its jobs
// and the back is done reading the history. Reset clears counters, queue and
// handshake state and sets the window length to its reset value, nothing else.
// A stalled rsp side holds the result register, the back, the queue, then req.
module centered_moving_average_filter #(
   parameter int MAX_HALF_WINDOW = 7,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_is_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_average,
   output logic                          rsp_last_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cmaf_pkg::WIN_W-1:0]    csr_data
);
   import cmaf_pkg::*;

   localparam int PEND_W  = $clog2(MAX_HALF_WINDOW + 2);
   localparam int IDX_W   = $clog2(2 * MAX_HALF_WINDOW + 1);
   localparam int ENTRY_W = PEND_W + $bits(job_type);
   localparam int Q_DEPTH = 4;

   logic [WIN_W-1:0]              window_size_ff;
   logic                          hist_busy;
   logic                          q_full, q_empty, q_push, q_pop;
   logic [PEND_W-1:0]             push_off;
   job_type                       push_job;
   logic [ENTRY_W-1:0]            q_data;
   logic [IDX_W-1:0]              hist_idx;
   logic signed [SAMPLE_BITS-1:0] hist_data;

   // Take window writes at any time; the user must issue them only while idle, the block does not enforce it.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         window_size_ff <= csr_data;
      end
   end

   cmaf_front #(
      .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_is_last(req_is_last),
      .window_size(window_size_ff),
      .hist_busy  (hist_busy),
      .q_full     (q_full),
      .q_empty    (q_empty),
      .push       (q_push),
      .push_off   (push_off),
      .push_job   (push_job),
      .hist_idx   (hist_idx),
      .hist_data  (hist_data)
   );

   // Jobs carry the output's offset back from the newest sample and its width.
   cmaf_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(Q_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data({push_off, push_job}),
      .pop      (q_pop),
      .pop_data (q_data),
      .full     (q_full),
      .empty    (q_empty)
   );

   cmaf_back #(
      .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_data),
      .pop         (q_pop),
      .hist_busy   (hist_busy),
      .hist_idx    (hist_idx),
      .hist_data   (hist_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_average (rsp_average),
      .rsp_last_out(rsp_last_out)
   );
endmodule
